FILE: rtl/rans_symbol_decoder_top_defines.svh
`ifndef RANS_SYMBOL_DECODER_TOP_DEFINES_SVH
`define RANS_SYMBOL_DECODER_TOP_DEFINES_SVH

// Implication check on clk_i, held off while in reset.
`define RSD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Invariant check on clk_i, held off while in reset.
`define RSD_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error(msg);

`endif

FILE: rtl/rsd_pkg.sv
package rsd_pkg;

  localparam int ALPHABET_SIZE = 512;
  localparam int MAX_CLUSTERS  = 16;

  localparam int SYM_W   = $clog2(ALPHABET_SIZE);
  localparam int CL_W    = $clog2(MAX_CLUSTERS);
  localparam int TAB_DEPTH = MAX_CLUSTERS * ALPHABET_SIZE;
  localparam int TAB_AW  = $clog2(TAB_DEPTH);

  // field widths
  localparam int OP_W    = 2;
  localparam int ID_W    = 16;
  localparam int TSYM_W  = 9;
  localparam int IV_W    = 13;
  localparam int BYTE_W  = 8;
  localparam int CFG_W   = 5;
  localparam int STAT_W  = 2;
  localparam int ENTRY_W = 2 * IV_W;

  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 16;

  localparam int PREC_BITS = 12;
  localparam logic [31:0] RENORM_BOUND = 32'h0040_0000;
  localparam logic [2:0]  INIT_BYTES   = 3'd4;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  typedef enum logic [OP_W-1:0] {
    OP_TABLE_WRITE = 2'd0,
    OP_RESTART     = 2'd1,
    OP_BYTE        = 2'd2,
    OP_DECODE      = 2'd3
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    STATUS_OK         = 2'd0,
    STATUS_NEED_BYTES = 2'd1,
    STATUS_NO_BYTE    = 2'd2
  } status_e;

  typedef struct packed {
    op_e               op;
    logic [CL_W-1:0]   cluster;
    logic              sym_ok;
    logic [TSYM_W-1:0] sym;
    logic [IV_W-1:0]   start;
    logic [IV_W-1:0]   freq;
    logic [BYTE_W-1:0] data;
  } cmd_t;

  function automatic logic [TAB_AW-1:0] tab_addr(logic [CL_W-1:0] cl,
                                                  logic [SYM_W-1:0] sym);
    tab_addr = TAB_AW'(cl) * TAB_AW'(ALPHABET_SIZE) + TAB_AW'(sym);
  endfunction

endpackage

FILE: rtl/rsd_ram.sv
module rsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/rsd_front.sv
module rsd_front
  import rsd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [IN_DATA_W-1:0] s_axis_tdata,
  input  logic [OP_W-1:0]      s_axis_tuser,
  output logic                 cmd_valid_o,
  input  logic                 cmd_ready_i,
  output cmd_t                 cmd_o
);

  localparam logic [CFG_W-1:0] MaxClCnt = CFG_W'(MAX_CLUSTERS);

  logic [CFG_W-1:0] cluster_count_q;
  cmd_t             q_q [QDEPTH];
  logic [QAW-1:0]   wptr_q, rptr_q;
  logic [QAW:0]     count_q;

  logic [CFG_W-1:0]  eff_count;
  logic [ID_W-1:0]   id;
  logic [TSYM_W-1:0] tsym;
  cmd_t              cmd_in;
  logic              push, pop;

  assign id   = s_axis_tdata[15:0];
  assign tsym = s_axis_tdata[24:16];

  // ids at or above the loaded count fall back to cluster 0
  assign eff_count = (cluster_count_q > MaxClCnt) ? MaxClCnt : cluster_count_q;

  always_comb begin
    cmd_in.op      = op_e'(s_axis_tuser);
    cmd_in.cluster = (id < ID_W'(eff_count)) ? CL_W'(id) : '0;
    cmd_in.sym_ok  = ({1'b0, tsym} < (TSYM_W + 1)'(ALPHABET_SIZE));
    cmd_in.sym     = tsym;
    cmd_in.start   = s_axis_tdata[37:25];
    cmd_in.freq    = s_axis_tdata[50:38];
    cmd_in.data    = s_axis_tdata[58:51];
  end

  assign s_axis_tready = (count_q != (QAW + 1)'(QDEPTH));
  assign cmd_valid_o   = (count_q != '0);
  assign cmd_o         = q_q[rptr_q];
  assign push          = s_axis_tvalid && s_axis_tready;
  assign pop           = cmd_valid_o && cmd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cluster_count_q <= CFG_W'(1);
      wptr_q          <= '0;
      rptr_q          <= '0;
      count_q         <= '0;
    end else begin
      if (cfg_we_i) begin
        cluster_count_q <= cfg_wdata_i;
      end
      if (push) begin
        wptr_q <= (wptr_q == QAW'(QDEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop) begin
        rptr_q <= (rptr_q == QAW'(QDEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_q[wptr_q] <= cmd_in;
    end
  end

endmodule

FILE: rtl/rsd_back.sv
module rsd_back
  import rsd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cmd_valid_i,
  output logic                  cmd_ready_o,
  input  cmd_t                  cmd_i,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic                  m_axis_tuser
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_MUL,
    S_ADD,
    S_RESP
  } state_e;

  state_e             state_q;
  logic [31:0]        coder_q;
  logic [2:0]         init_q;
  logic [CL_W-1:0]    cl_q;
  logic [SYM_W:0]     issue_q;
  logic               chk_vld_q;
  logic [SYM_W-1:0]   chk_idx_q;
  logic [IV_W-1:0]    e0_start_q, e0_freq_q;
  logic [IV_W-1:0]    hit_start_q, hit_freq_q;
  logic [SYM_W-1:0]   hit_sym_q;
  logic [31:0]        prod_q;
  logic [TSYM_W-1:0]  res_sym_q;
  logic               res_valid_q;
  status_e            res_status_q;
  logic               m_valid_q;
  logic [TSYM_W-1:0]  m_sym_q;
  logic               m_symv_q;
  status_e            m_status_q;
  logic               m_need_q;

  logic                ram_we, ram_re;
  logic [TAB_AW-1:0]   ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0]  ram_wdata, ram_rdata;
  logic [IV_W-1:0]     rd_start, rd_freq;
  logic [PREC_BITS-1:0] slot;
  logic                hit;
  logic                need_now;
  logic                out_free;

  rsd_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TAB_DEPTH)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign cmd_ready_o = (state_q == S_IDLE);

  assign ram_we    = (state_q == S_IDLE) && cmd_valid_i && (cmd_i.op == OP_TABLE_WRITE) &&
                     cmd_i.sym_ok;
  assign ram_waddr = tab_addr(cmd_i.cluster, SYM_W'(cmd_i.sym));
  assign ram_wdata = {cmd_i.start, cmd_i.freq};

  assign ram_re    = (state_q == S_SCAN) && (issue_q < (SYM_W + 1)'(ALPHABET_SIZE));
  assign ram_raddr = tab_addr(cl_q, issue_q[SYM_W-1:0]);

  assign rd_start = ram_rdata[ENTRY_W-1:IV_W];
  assign rd_freq  = ram_rdata[IV_W-1:0];
  assign slot     = coder_q[PREC_BITS-1:0];

  // start <= slot < start + freq, all unsigned
  assign hit = chk_vld_q && (rd_start <= IV_W'(slot)) &&
               ((IV_W + 1)'(slot) < ((IV_W + 1)'(rd_start) + (IV_W + 1)'(rd_freq)));

  assign need_now = (init_q < INIT_BYTES) || (coder_q < RENORM_BOUND);
  assign out_free = !m_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      coder_q      <= '0;
      init_q       <= '0;
      cl_q         <= '0;
      issue_q      <= '0;
      chk_vld_q    <= 1'b0;
      chk_idx_q    <= '0;
      e0_start_q   <= '0;
      e0_freq_q    <= '0;
      hit_start_q  <= '0;
      hit_freq_q   <= '0;
      hit_sym_q    <= '0;
      prod_q       <= '0;
      res_sym_q    <= '0;
      res_valid_q  <= 1'b0;
      res_status_q <= STATUS_OK;
      m_valid_q    <= 1'b0;
      m_sym_q      <= '0;
      m_symv_q     <= 1'b0;
      m_status_q   <= STATUS_OK;
      m_need_q     <= 1'b0;
    end else begin
      // S_RESP loads the output register itself
      if (m_valid_q && m_axis_tready && (state_q != S_RESP)) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (cmd_valid_i) begin
            res_sym_q   <= '0;
            res_valid_q <= 1'b0;
            case (cmd_i.op)
              OP_TABLE_WRITE: begin
                res_status_q <= STATUS_OK;
                state_q      <= S_RESP;
              end
              OP_RESTART: begin
                coder_q      <= '0;
                init_q       <= '0;
                res_status_q <= STATUS_OK;
                state_q      <= S_RESP;
              end
              OP_BYTE: begin
                state_q <= S_RESP;
                if (init_q < INIT_BYTES) begin
                  // little-endian fill of the initial state
                  coder_q      <= coder_q | (32'(cmd_i.data) << {init_q[1:0], 3'b000});
                  init_q       <= init_q + 1'b1;
                  res_status_q <= STATUS_OK;
                end else if (coder_q < RENORM_BOUND) begin
                  coder_q      <= {coder_q[31-BYTE_W:0], cmd_i.data};
                  res_status_q <= STATUS_OK;
                end else begin
                  res_status_q <= STATUS_NO_BYTE;
                end
              end
              OP_DECODE: begin
                if (need_now) begin
                  res_status_q <= STATUS_NEED_BYTES;
                  state_q      <= S_RESP;
                end else begin
                  res_status_q <= STATUS_OK;
                  cl_q         <= cmd_i.cluster;
                  issue_q      <= '0;
                  chk_vld_q    <= 1'b0;
                  state_q      <= S_SCAN;
                end
              end
              default: begin
                res_status_q <= STATUS_OK;
                state_q      <= S_RESP;
              end
            endcase
          end
        end
        S_SCAN: begin
          chk_vld_q <= ram_re;
          if (ram_re) begin
            issue_q   <= issue_q + 1'b1;
            chk_idx_q <= issue_q[SYM_W-1:0];
          end
          if (chk_vld_q) begin
            if (chk_idx_q == '0) begin
              e0_start_q <= rd_start;
              e0_freq_q  <= rd_freq;
            end
            if (hit) begin
              hit_start_q <= rd_start;
              hit_freq_q  <= rd_freq;
              hit_sym_q   <= chk_idx_q;
              state_q     <= S_MUL;
            end else if (chk_idx_q == SYM_W'(ALPHABET_SIZE - 1)) begin
              // no interval holds the slot: fall back to symbol 0
              hit_start_q <= e0_start_q;
              hit_freq_q  <= e0_freq_q;
              hit_sym_q   <= '0;
              state_q     <= S_MUL;
            end
          end
        end
        S_MUL: begin
          prod_q  <= 32'(hit_freq_q * coder_q[31:PREC_BITS]);
          state_q <= S_ADD;
        end
        S_ADD: begin
          coder_q     <= prod_q + 32'(slot) - 32'(hit_start_q);
          res_sym_q   <= TSYM_W'(hit_sym_q);
          res_valid_q <= 1'b1;
          state_q     <= S_RESP;
        end
        S_RESP: begin
          if (out_free) begin
            m_valid_q  <= 1'b1;
            m_sym_q    <= res_sym_q;
            m_symv_q   <= res_valid_q;
            m_status_q <= res_status_q;
            m_need_q   <= need_now;
            state_q    <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_symv_q;
  assign m_axis_tdata  = OUT_DATA_W'({m_need_q, m_status_q, m_sym_q});

endmodule

FILE: rtl/rans_symbol_decoder_top.sv
// rANS symbol decoder with static per-cluster tables (12-bit precision, byte renormalization
// to 2^22). Each input transfer carries one command in s_axis_tuser: table write, stream
// restart, stream byte or symbol decode; every command returns exactly one result transfer.
// Commands land in a 4-deep queue and are executed one at a time by the back end, so the
// input side keeps taking transfers while a result waits on m_axis until the queue fills.
// Table writes, restarts and bytes pass through S_RESP to the result. A decode scans the
// cluster's table in the 8192x26 table RAM one entry per cycle through its single read
// port, stopping at the first hit or, if no interval holds the slot, after the last entry
// with symbol 0. The table RAM is not cleared at reset; decode only over written entries.
// cluster_count (cfg_wdata_i) may be written only while the block is idle.
`include "rans_symbol_decoder_top_defines.svh"

module rans_symbol_decoder_top
  import rsd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_W-1:0]      cfg_wdata_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [15:0] cluster, [24:16] table_symbol, [37:25] interval_start,
  // [50:38] interval_freq, [58:51] data_byte, [63:59] zero
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // [1:0] opcode
  input  logic [OP_W-1:0]       s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [8:0] symbol, [10:9] status, [11] need_bytes, [15:12] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // [0] symbol_valid
  output logic                  m_axis_tuser
);

  cmd_t cmd;
  logic cmd_valid, cmd_ready;

  rsd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .cmd_valid_o  (cmd_valid),
    .cmd_ready_i  (cmd_ready),
    .cmd_o        (cmd)
  );

  rsd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (cmd_valid),
    .cmd_ready_o  (cmd_ready),
    .cmd_i        (cmd),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // a decoded symbol always comes with an ok status
  `RSD_ASSERT_IMP(a_symbol_status_ok, m_axis_tvalid && m_axis_tuser, m_axis_tdata[10:9] == STATUS_OK, "symbol with non-ok status")
  // a rejected decode leaves the state short of bytes
  `RSD_ASSERT_IMP(a_reject_needs_bytes, m_axis_tvalid && (m_axis_tdata[10:9] == STATUS_NEED_BYTES), m_axis_tdata[11] && !m_axis_tuser, "rejected decode without need_bytes")
  // a dropped byte means the state was full
  `RSD_ASSERT_ALWAYS(a_drop_when_full, !(m_axis_tvalid && (m_axis_tdata[10:9] == STATUS_NO_BYTE) && m_axis_tdata[11]), "byte dropped while bytes needed")

endmodule
